// ===== rtl/integer_to_ascii_radix_macros.svh =====
// Assertion macros for the integer_to_ascii_radix RTL.
// Used by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_MACROS_SVH
`define INTEGER_TO_ASCII_RADIX_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication.
`define ITAR_ASSERT_IMPL(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |-> (con)) \
        else $error(msg);
// Next-cycle implication.
`define ITAR_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ant) |=> (con)) \
        else $error(msg);
`else
`define ITAR_ASSERT_IMPL(lbl, ant, con, msg)
`define ITAR_ASSERT_NEXT(lbl, ant, con, msg)
`endif

`endif

// ===== rtl/itar_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function for integer_to_ascii_radix.
// No dependencies.
package itar_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int RADIX_W        = 5;
    localparam int CHAR_W         = 7;
    localparam int DIGIT_W        = 4;
    // Dividend bits retired per divider cycle.
    localparam int STEP_BITS      = 8;

    localparam logic [RADIX_W-1:0] RADIX_DEFAULT = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_DEC     = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX_DEC = 4'd9;

    localparam logic [CHAR_W-1:0] CH_ZERO     = 7'h30;
    localparam logic [CHAR_W-1:0] CH_LETTER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CH_MINUS    = 7'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic div_last;
        logic rd;
        logic emit_sign;
        logic emit_digit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic radix_ok;
        logic neg;
        logic quo_zero;
        logic cnt_full;
        logic cnt_one;
        logic out_free;
    } t_sts;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d > DIGIT_MAX_DEC) begin
            return ext + (CH_LETTER_A - CHAR_W'(RADIX_DEC));
        end else begin
            return ext + CH_ZERO;
        end
    endfunction

endpackage

// ===== rtl/itar_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itar_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/itar_ctrl.sv =====
// Sequencing controller: accept, divide digit by digit, then emit sign and digits.
// Depends on itar_pkg and integer_to_ascii_radix_macros.svh.
`include "integer_to_ascii_radix_macros.svh"

module itar_ctrl #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  itar_pkg::t_sts i_sts,
    output itar_pkg::t_cmd o_cmd
);
    import itar_pkg::*;

    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;

    t_state        r_state, n_state;
    logic [SW-1:0] r_step,  n_step;
    t_cmd          w_cmd;
    logic          w_step_last;

    assign w_step_last = (r_step == SW'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        w_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    // Out-of-range radix: take the beat, emit nothing
                    if (i_sts.radix_ok) begin
                        n_state = S_DIV;
                        n_step  = '0;
                    end
                end
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                if (w_step_last) begin
                    w_cmd.div_last = 1'b1;
                    n_step         = '0;
                    if (i_sts.quo_zero || i_sts.cnt_full) begin
                        n_state = i_sts.neg ? S_SIGN : S_READ;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_SIGN: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_sign = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                w_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_digit = 1'b1;
                    n_state          = i_sts.cnt_one ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = w_cmd;

    `ITAR_ASSERT_IMPL(a_load_needs_room, w_cmd.emit_sign || w_cmd.emit_digit, i_sts.out_free, "output register overwritten")
    `ITAR_ASSERT_NEXT(a_bad_radix_idle, (r_state == S_IDLE) && i_in_valid && !i_sts.radix_ok, r_state == S_IDLE, "conversion started with bad radix")
    `ITAR_ASSERT_NEXT(a_last_digit_idle, w_cmd.emit_digit && i_sts.cnt_one, r_state == S_IDLE, "digits left after last beat")
    `ITAR_ASSERT_IMPL(a_step_range, r_state == S_DIV, r_step <= SW'(STEPS - 1), "divider step out of range")

endmodule

// ===== rtl/itar_dp.sv =====
// Datapath: radix register, shared 8-bit-per-cycle divider, digit RAM, output register.
// Depends on itar_pkg, itar_ram and integer_to_ascii_radix_macros.svh.
`include "integer_to_ascii_radix_macros.svh"

module itar_dp #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [itar_pkg::RADIX_W-1:0]  i_cfg_data,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    input  itar_pkg::t_cmd                i_cmd,
    output itar_pkg::t_sts                o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [itar_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_last
);
    import itar_pkg::*;

    localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int DW    = STEPS * STEP_BITS;
    localparam int CW    = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);

    logic [RADIX_W-1:0]    r_radix;
    logic [DW-1:0]         r_div;
    logic [DIGIT_W-1:0]    r_part;
    logic [CW-1:0]         r_cnt;
    logic                  r_neg;
    logic                  r_out_valid;
    logic [CHAR_W-1:0]     r_out_char;
    logic                  r_out_last;

    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_mag;
    logic                  w_neg;
    logic [DW-1:0]         v_div;
    logic [DIGIT_W-1:0]    v_part;
    logic [RADIX_W-1:0]    v_t;
    logic [CW-1:0]         w_rd_idx;
    logic [DIGIT_W-1:0]    w_ram_q;
    logic                  w_out_free;

    assign w_val = i_value;
    assign w_neg = (r_radix == RADIX_DEC) && w_val[VALUE_BITS-1];
    // Most negative value negates to itself, which reads as the right magnitude
    assign w_mag = w_neg ? (~w_val + 1'b1) : w_val;

    // Restoring division by the radix, STEP_BITS dividend bits per cycle;
    // quotient bits shift in at the bottom as dividend bits leave the top
    always_comb begin
        v_div  = r_div;
        v_part = r_part;
        v_t    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            v_t   = {v_part, v_div[DW-1]};
            v_div = {v_div[DW-2:0], 1'b0};
            if (v_t >= r_radix) begin
                v_t      = v_t - r_radix;
                v_div[0] = 1'b1;
            end
            v_part = v_t[DIGIT_W-1:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_rd_idx   = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_DEFAULT;
        end else if (i_cfg_valid) begin
            r_radix <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div  <= '0;
            r_part <= '0;
            r_cnt  <= '0;
            r_neg  <= 1'b0;
        end else if (i_cmd.load) begin
            r_div  <= DW'(w_mag);
            r_part <= '0;
            r_cnt  <= '0;
            r_neg  <= w_neg;
        end else if (i_cmd.div_step) begin
            r_div  <= v_div;
            r_part <= i_cmd.div_last ? '0 : v_part;
            if (i_cmd.div_last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end else if (i_cmd.emit_digit) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    itar_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.div_last),
        .i_wr_addr (r_cnt[AW-1:0]),
        .i_wr_data (v_part),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (w_rd_idx[AW-1:0]),
        .o_rd_data (w_ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sign || i_cmd.emit_digit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sign) begin
            r_out_char <= CH_MINUS;
            r_out_last <= 1'b0;
        end else if (i_cmd.emit_digit) begin
            r_out_char <= digit_char(w_ram_q);
            r_out_last <= (r_cnt == CW'(1));
        end
    end

    assign o_sts.radix_ok = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    assign o_sts.neg      = r_neg;
    assign o_sts.quo_zero = (v_div == '0);
    assign o_sts.cnt_full = (r_cnt == CW'(VALUE_BITS - 1));
    assign o_sts.cnt_one  = (r_cnt == CW'(1));
    assign o_sts.out_free = w_out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last      = r_out_last;

    `ITAR_ASSERT_IMPL(a_cnt_range, 1'b1, r_cnt <= CW'(VALUE_BITS), "digit count beyond store depth")
    `ITAR_ASSERT_IMPL(a_write_in_range, i_cmd.div_last, r_cnt < CW'(VALUE_BITS), "digit write past store end")
    `ITAR_ASSERT_IMPL(a_part_below_radix, i_cmd.div_step, {1'b0, r_part} < r_radix, "partial remainder not below radix")
    `ITAR_ASSERT_IMPL(a_emit_has_digit, i_cmd.emit_digit || i_cmd.rd, r_cnt != '0, "digit read with empty store")

endmodule

// ===== rtl/integer_to_ascii_radix.sv =====
// Top level of integer_to_ascii_radix: controller plus datapath.
// Depends on itar_pkg, itar_ctrl and itar_dp.
//
// Converts one signed VALUE_BITS-bit integer per input beat into its ASCII text in the
// radix held by the configuration register (2..16, reset 10), most significant character
// first, lower-case letters for digits above 9, o_last on the final character. In radix
// ten a negative value is preceded by '-'; in other radices it is written as its unsigned
// two's-complement pattern. A radix register value outside 2..16 swallows the beat and
// emits nothing. One item is in flight at a time: the value is accepted, then each digit
// is computed in the shared divider (8 quotient bits per cycle), then each character is
// read out of the registered digit RAM and loaded into the output register, after a
// minus sign if there is one, waiting while the output stalls. The next value is taken
// in the cycle after the last character enters the output register.
module integer_to_ascii_radix #(
    parameter int VALUE_BITS = itar_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [itar_pkg::RADIX_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_BITS-1:0]  i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [itar_pkg::CHAR_W-1:0]   o_out_char,
    output logic                          o_last
);
    import itar_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // Register writes must arrive only while idle; the block itself does not enforce this
    assign o_cfg_ready = 1'b1;

    itar_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    itar_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_value     (i_value),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for integer_to_ascii_radix: directed and random values across radices.
// Depends on itar_pkg and the integer_to_ascii_radix RTL; predicts each character stream itself.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itar_pkg::*;

    localparam int VW           = VALUE_BITS_DEF;
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int IDLE_PCT     = 13;
    localparam int PHASE_ITEMS  = 22;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_text_char;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [RADIX_W-1:0]    i_cfg_data  = RADIX_DEC;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic signed [VW-1:0]  i_value     = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [CHAR_W-1:0]     o_out_char;
    logic                  o_last;

    t_text_char            expected_text[$];
    logic [RADIX_W-1:0]    cur_radix  = RADIX_DEFAULT;
    logic                  quiet_mode = 1'b0;
    int                    fail_count = 0;
    int                    cycle_count = 0;

    integer_to_ascii_radix #(.VALUE_BITS(VW)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_char  (o_out_char),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL integer_to_ascii_radix");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
    end

    // Compare every accepted character beat with the oldest predicted one.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_text.size() == 0) begin
                $error("unexpected beat: out_char %h last %b", o_out_char, o_last);
                fail_count++;
            end else begin
                want = expected_text.pop_front();
                if (o_out_char !== want.ch) begin
                    $error("out_char: expected %h, actual %h", want.ch, o_out_char);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // Build the text of one value in the current radix, most significant character first.
    function automatic void predict_text(input logic [VW-1:0] value);
        logic [VW-1:0]      magnitude;
        logic [VW-1:0]      base;
        logic [DIGIT_W-1:0] digits [VW];
        logic [CHAR_W-1:0]  ch;
        logic               minus;
        int                 ndig;
        int                 k;
        base  = VW'(cur_radix);
        minus = (cur_radix == RADIX_DEC) && value[VW-1];
        // Negation wraps the most negative value onto its own magnitude.
        magnitude = minus ? (~value + 1'b1) : value;
        ndig = 0;
        do begin
            digits[ndig] = DIGIT_W'(magnitude % base);
            magnitude    = magnitude / base;
            ndig++;
        end while (magnitude != 0);
        if (minus) begin
            expected_text.push_back('{ch: CH_MINUS, last: 1'b0});
        end
        for (k = ndig - 1; k >= 0; k--) begin
            if (digits[k] > DIGIT_MAX_DEC) begin
                ch = CH_LETTER_A + CHAR_W'(digits[k]) - CHAR_W'(RADIX_DEC);
            end else begin
                ch = CH_ZERO + CHAR_W'(digits[k]);
            end
            expected_text.push_back('{ch: ch, last: (k == 0)});
        end
    endfunction

    function automatic logic [VW-1:0] rand_value();
        logic [VW-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = VW'($urandom_range(20));
            2: v = -VW'($urandom_range(1, 20));
            3: begin
                case ($urandom_range(3))
                    0: v = '0;
                    1: v = '1;
                    2: v = {1'b1, {(VW-1){1'b0}}};
                    default: v = {1'b0, {(VW-1){1'b1}}};
                endcase
            end
            4: v = $urandom >> $urandom_range(31);
            default: v = -($urandom >> $urandom_range(31));
        endcase
        return v;
    endfunction

    // Offer one value; valid stays high so back-to-back beats need no extra edge.
    task automatic send_value(input logic [VW-1:0] value);
        int gap;
        gap = 0;
        while (!quiet_mode && ($urandom_range(99) < IDLE_PCT)) begin
            gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
        predict_text(value);
    endtask

    // Hold the input until every predicted character has been seen.
    task automatic wait_text_drained();
        i_in_valid <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [RADIX_W-1:0] radix);
        wait_text_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= radix;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_radix = radix;
    endtask

    task automatic test_reset_radix_decimal();
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'h7fffffff);
        send_value(32'h80000000);
        send_value(-32'sd10);
        send_value(32'd1000000000);
        send_value(32'haaaaaaaa);
        send_value(32'h55555555);
    endtask

    task automatic test_radix_extremes();
        write_radix(RADIX_MAX);
        send_value(32'd0);
        send_value(32'hffffffff);
        send_value(32'h80000000);
        send_value(32'hfedcba98);
        send_value(32'h01234567);
        write_radix(RADIX_MIN);
        send_value(32'd0);
        send_value(32'd1);
        send_value(32'hffffffff);
        send_value(32'h80000000);
        write_radix(5'd3);
        send_value(32'hffffffff);
        send_value(32'd8);
        write_radix(5'd15);
        send_value(32'h7fffffff);
        send_value(-32'sd1);
    endtask

    task automatic test_random_phases();
        logic [RADIX_W-1:0] radix;
        int phase;
        for (phase = 0; phase < 9; phase++) begin
            case (phase)
                0: radix = RADIX_MIN;
                1: radix = RADIX_MAX;
                2: radix = RADIX_DEC;
                3: radix = 5'd8;
                default: radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            endcase
            write_radix(radix);
            quiet_mode = (phase == 4);
            repeat (PHASE_ITEMS) send_value(rand_value());
            quiet_mode = 1'b0;
        end
    endtask

    // Sender holds off after every fourth beat until all text is out.
    task automatic test_sender_pause();
        int n;
        write_radix(RADIX_DEC);
        for (n = 0; n < PHASE_ITEMS; n++) begin
            send_value(rand_value());
            if (n % 4 == 3) begin
                wait_text_drained();
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_radix_decimal();
        test_radix_extremes();
        test_random_phases();
        test_sender_pause();
        wait_text_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS integer_to_ascii_radix");
        end else begin
            $display("FAIL integer_to_ascii_radix");
        end
        $finish;
    end

endmodule
